### sv/vdp_hp_pkg.sv
`default_nettype none

package vdp_hp_pkg;

	// Video memory size; the pointer itself is always 14 bits wide
	localparam int VRAM_DEPTH = 16384;
	localparam int VRAM_AW    = $clog2(VRAM_DEPTH);
	localparam int PTR_W      = 14;

	// Status bits cleared by a status read (frame flag and collision flag)
	localparam logic [7:0] STATUS_CLEAR = 8'b1010_0000;

	// Second control byte fields
	localparam int CTL_REG_BIT   = 7;
	localparam int CTL_NOREAD_BIT = 6;

	typedef enum logic [1:0] {
		MODE_READ   = 2'd0,
		MODE_WRITE  = 2'd1,
		MODE_STATUS = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	typedef enum logic {
		PORT_DATA = 1'b0,
		PORT_CTRL = 1'b1
	} port_t;

	// Request to video memory for one word
	typedef struct packed {
		logic               we;
		logic               re;
		logic [VRAM_AW-1:0] addr;
		logic [7:0]         wdata;
	} vram_cmd_t;

	// Result word of one access
	typedef struct packed {
		logic [7:0] read_data;
		logic       reg_written;
		logic [2:0] reg_index;
		logic [7:0] reg_value;
	} result_t;

endpackage

`default_nettype wire

### sv/vdp_hp_vram.sv
`default_nettype none

module vdp_hp_vram (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire vdp_hp_pkg::vram_cmd_t cmd,
	output logic [7:0]                 read_ahead
);
	import vdp_hp_pkg::*;

	logic [7:0] mem [VRAM_DEPTH];
	logic [7:0] read_ahead_q;

	// Store a written word
	always_ff @(posedge clk) begin
		if (cmd.we) begin
			mem[cmd.addr] <= cmd.wdata;
		end
	end

	// Refill the read-ahead byte; it is the registered read port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_ahead_q <= '0;
		end else if (cmd.re) begin
			read_ahead_q <= mem[cmd.addr];
		end
	end

	assign read_ahead = read_ahead_q;

endmodule

`default_nettype wire

### sv/vdp_hp_ctrl.sv
`default_nettype none

module vdp_hp_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  advance,
	input  wire logic [1:0]            mode,
	input  wire logic                  port,
	input  wire logic [7:0]            write_data,
	input  wire logic [7:0]            read_ahead,
	output vdp_hp_pkg::vram_cmd_t      cmd,
	output vdp_hp_pkg::result_t        result
);
	import vdp_hp_pkg::*;

	logic [PTR_W-1:0] ptr_q, ptr_d, ptr_set;
	logic [7:0]       latch_q, latch_d;
	logic             phase_q, phase_d;
	logic [7:0]       status_q, status_d;
	vram_cmd_t        cmd_c;
	result_t          res_c;

	assign ptr_set = {write_data[5:0], latch_q};

	// Decode one access
	always_comb begin
		ptr_d    = ptr_q;
		latch_d  = latch_q;
		phase_d  = phase_q;
		status_d = status_q;
		cmd_c    = '0;
		res_c    = '0;
		case (mode_t'(mode))
			MODE_READ: begin
				phase_d = 1'b0;
				if (port_t'(port) == PORT_DATA) begin
					res_c.read_data = read_ahead;
					cmd_c.re        = 1'b1;
					cmd_c.addr      = ptr_q[VRAM_AW-1:0];
					ptr_d           = ptr_q + 1'b1;
				end else begin
					res_c.read_data = status_q;
					status_d        = status_q & ~STATUS_CLEAR;
				end
			end
			MODE_WRITE: begin
				if (port_t'(port) == PORT_DATA) begin
					cmd_c.we    = 1'b1;
					cmd_c.addr  = ptr_q[VRAM_AW-1:0];
					cmd_c.wdata = write_data;
					ptr_d       = ptr_q + 1'b1;
					phase_d     = 1'b0;
				end else if (!phase_q) begin
					latch_d = write_data;
					phase_d = 1'b1;
				end else begin
					phase_d = 1'b0;
					if (write_data[CTL_REG_BIT]) begin
						res_c.reg_written = 1'b1;
						res_c.reg_index   = write_data[2:0];
						res_c.reg_value   = latch_q;
					end else if (write_data[CTL_NOREAD_BIT]) begin
						ptr_d = ptr_set;
					end else begin
						// address set with prefetch
						cmd_c.re   = 1'b1;
						cmd_c.addr = ptr_set[VRAM_AW-1:0];
						ptr_d      = ptr_set + 1'b1;
					end
				end
			end
			MODE_STATUS: begin
				status_d = status_q | write_data;
			end
			default: begin
			end
		endcase
		if (!advance) begin
			cmd_c.we = 1'b0;
			cmd_c.re = 1'b0;
		end
	end

	// Advance host state on each word taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q    <= '0;
			latch_q  <= '0;
			phase_q  <= 1'b0;
			status_q <= '0;
		end else if (advance) begin
			ptr_q    <= ptr_d;
			latch_q  <= latch_d;
			phase_q  <= phase_d;
			status_q <= status_d;
		end
	end

	assign cmd    = cmd_c;
	assign result = res_c;

endmodule

`default_nettype wire

### sv/vdp_host_port.sv
// Channel   Handshake               Payload
// request   req_valid / req_ready   mode, port, write_data
// response  rsp_valid / rsp_ready   read_data, reg_written, reg_index, reg_value
//
// One word per cycle while the response is not stalled; a taken word is held in the input stage,
// then loaded into the response register after one pass of decode and memory access.
// The single video memory port (one write or one read-ahead refill) sets this rate.
// A stalled response holds the stage behind it; the input stage drains as soon
// as the response register frees. Reset clears pointer, latch, phase, status
// and read-ahead; video memory content is undefined until written.
`default_nettype none

module vdp_host_port (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	output logic            req_ready,
	input  wire logic [1:0] mode,
	input  wire logic       port,
	input  wire logic [7:0] write_data,
	output logic            rsp_valid,
	input  wire logic       rsp_ready,
	output logic [7:0]      read_data,
	output logic            reg_written,
	output logic [2:0]      reg_index,
	output logic [7:0]      reg_value
);
	import vdp_hp_pkg::*;

	logic       valid_s1;
	logic [1:0] mode_s1;
	logic       port_s1;
	logic [7:0] data_s1;
	logic       advance;
	logic       out_valid_q;
	result_t    out_q;
	result_t    result;
	vram_cmd_t  cmd;
	logic [7:0] read_ahead;

	assign advance   = valid_s1 && (!out_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || advance;

	// Capture the incoming word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			mode_s1 <= mode;
			port_s1 <= port;
			data_s1 <= write_data;
		end
	end

	vdp_hp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.mode       (mode_s1),
		.port       (port_s1),
		.write_data (data_s1),
		.read_ahead (read_ahead),
		.cmd        (cmd),
		.result     (result)
	);

	vdp_hp_vram u_vram (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.read_ahead (read_ahead)
	);

	// Hold the result word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= result;
		end
	end

	assign rsp_valid   = out_valid_q;
	assign read_data   = out_q.read_data;
	assign reg_written = out_q.reg_written;
	assign reg_index   = out_q.reg_index;
	assign reg_value   = out_q.reg_value;

endmodule

`default_nettype wire

### sv/vdp_hp_checker.sv
`default_nettype none

module vdp_hp_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       req_valid,
	input wire logic       req_ready,
	input wire logic       rsp_valid,
	input wire logic       rsp_ready,
	input wire logic [7:0] read_data,
	input wire logic       reg_written,
	input wire logic [2:0] reg_index,
	input wire logic [7:0] reg_value
);

	// A stalled response keeps its valid, read data, register flag and register value
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_data)
			&& $stable(reg_written) && $stable(reg_value))
		else $error("response word changed while stalled");

	// A word taken passes through the input stage to the response while the sink is ready
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) ##1 rsp_ready |=> rsp_valid)
		else $error("response missing after accepted request");

	// A register write is never a read
	a_reg_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && reg_written |-> read_data == 8'd0)
		else $error("register write returned read data");

	// Register fields are zero without a register write
	a_reg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !reg_written |-> reg_index == 3'd0 && reg_value == 8'd0)
		else $error("register fields set without register write");

endmodule

bind vdp_host_port vdp_hp_checker u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req_valid),
	.req_ready   (req_ready),
	.rsp_valid   (rsp_valid),
	.rsp_ready   (rsp_ready),
	.read_data   (read_data),
	.reg_written (reg_written),
	.reg_index   (reg_index),
	.reg_value   (reg_value)
);

`default_nettype wire
